// ===== hw/rtl/rdsp_pkg.sv =====
// types, constants and helper functions shared by the radix digit string unit
`timescale 1ns / 1ps
`default_nettype none

package rdsp_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 31;

    // fixed field widths
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    // radix register limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // ascii offsets for the digit characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 7'd55;
    localparam logic [DIGIT_W-1:0] DECIMAL_TOP = 6'd10;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'd0;

    // classified word handed from front to back
    typedef struct packed {
        logic [RADIX_W-1:0] base;
        logic               zero;
    } rdsp_ctrl_t;

    // digit value to its character, 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < DECIMAL_TOP)
            digit_to_char = CHAR_ZERO + dx;
        else
            digit_to_char = CHAR_ALPHA + dx;
    endfunction

    // radix clamped to the supported range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            clamp_radix = RADIX_MIN;
        else if (r > RADIX_MAX)
            clamp_radix = RADIX_MAX;
        else
            clamp_radix = r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdsp_front.sv =====
// front end: radix register, input classification and a two-entry hand-off queue
`timescale 1ns / 1ps
`default_nettype none

module rdsp_front #(
    parameter int VALUE_BITS = rdsp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          radix_we,
    input  wire logic [rdsp_pkg::RADIX_W-1:0]  radix_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [VALUE_BITS-1:0]         number,
    output logic                               item_valid,
    input  wire logic                          item_take,
    output logic [VALUE_BITS-1:0]              item_value,
    output rdsp_pkg::rdsp_ctrl_t               item_ctrl
);
    import rdsp_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] q_val_reg [Q_DEPTH];
    rdsp_ctrl_t            q_ctl_reg [Q_DEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push_ok;
    rdsp_ctrl_t            new_ctl;

    // radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (radix_we)
            radix_reg <= radix_wdata;
    end

    // classify the incoming word
    always_comb
    begin
        new_ctl.base = clamp_radix(radix_reg);
        new_ctl.zero = (number == '0);
    end

    // queue pointers and fill count
    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign push_ok    = push && !full;
    assign item_valid = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_ok) - CNT_W'(item_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_val_reg[wr_ptr_reg] <= number;
            q_ctl_reg[wr_ptr_reg] <= new_ctl;
        end
    end

    assign item_value = q_val_reg[rd_ptr_reg];
    assign item_ctrl  = q_ctl_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("hand-off queue overfilled");
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> count_reg != '0)
        else $error("back end took a word from an empty queue");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> count_reg != '0)
        else $error("accepted word not held in queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rdsp_back.sv =====
// back end: serial divider, digit store, palindrome check and result register
`timescale 1ns / 1ps
`default_nettype none

module rdsp_back #(
    parameter int VALUE_BITS = rdsp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdsp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_take,
    input  wire logic [VALUE_BITS-1:0]         item_value,
    input  wire rdsp_pkg::rdsp_ctrl_t          item_ctrl,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rdsp_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit,
    output logic                               empty_string,
    output logic                               palindrome
);
    import rdsp_pkg::*;

    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_PAL_RD  = 3'd2;
    localparam logic [2:0] S_PAL_CMP = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_WR = 3'd5;
    localparam logic [2:0] S_ZERO    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pal_reg, pal_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    base_reg;

    logic [DIGIT_W:0]      trial;
    logic                  ge;
    logic [DIGIT_W-1:0]    rem_step;
    logic [VALUE_BITS-1:0] val_step;
    logic [CNT_W-1:0]      dcnt_inc;
    logic [CNT_W-1:0]      mirror_idx;

    logic [DIGIT_W-1:0]    mem [MAX_DIGITS];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic                  rd_en_a, rd_en_b;
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;
    logic [DIGIT_W-1:0]    rd_a_reg, rd_b_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;
    logic                  out_load;
    logic [CHAR_W-1:0]     out_char;
    logic                  out_last, out_empty, out_pal;
    logic [CHAR_W-1:0]     digit_char_reg;
    logic                  last_digit_reg, empty_string_reg, palindrome_reg;

    // one restoring division step by the radix
    always_comb
    begin
        trial    = {rem_reg, val_reg[VALUE_BITS-1]};
        ge       = (trial >= {1'b0, base_reg});
        rem_step = ge ? DIGIT_W'(trial - {1'b0, base_reg}) : trial[DIGIT_W-1:0];
        val_step = {val_reg[VALUE_BITS-2:0], ge};
    end

    assign dcnt_inc   = dcnt_reg + 1'b1;
    assign mirror_idx = dcnt_reg - 1'b1 - idx_reg;
    assign slot_free  = !out_valid_reg || pop;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dcnt_next    = dcnt_reg;
        idx_next     = idx_reg;
        pal_next     = pal_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        item_take    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = dcnt_reg[ADDR_W-1:0];
        rd_en_a      = 1'b0;
        rd_en_b      = 1'b0;
        rd_addr_a    = idx_reg[ADDR_W-1:0];
        rd_addr_b    = mirror_idx[ADDR_W-1:0];
        out_load     = 1'b0;
        out_char     = digit_to_char(rd_a_reg);
        out_last     = (idx_reg == '0);
        out_empty    = 1'b0;
        out_pal      = pal_reg && (idx_reg == '0);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take    = 1'b1;
                    val_next     = item_value;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    dcnt_next    = '0;
                    pal_next     = 1'b1;
                    state_next   = item_ctrl.zero ? S_ZERO : S_DIV;
                end
            end
            S_DIV:
            begin
                val_next     = val_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_W'(VALUE_BITS - 1))
                begin
                    // digit complete: store it, then go on with the quotient unless it is zero or the store is full
                    mem_we       = 1'b1;
                    dcnt_next    = dcnt_inc;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (val_step == '0 || dcnt_inc == CNT_W'(MAX_DIGITS))
                    begin
                        idx_next   = '0;
                        state_next = S_PAL_RD;
                    end
                end
            end
            S_PAL_RD:
            begin
                if (idx_reg < (dcnt_reg >> 1))
                begin
                    rd_en_a    = 1'b1;
                    rd_en_b    = 1'b1;
                    state_next = S_PAL_CMP;
                end
                else
                begin
                    idx_next   = dcnt_reg - 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            S_PAL_CMP:
            begin
                if (rd_a_reg != rd_b_reg)
                    pal_next = 1'b0;
                idx_next   = idx_reg + 1'b1;
                state_next = S_PAL_RD;
            end
            S_EMIT_RD:
            begin
                rd_en_a    = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_ZERO:
            begin
                out_char  = CHAR_NONE;
                out_last  = 1'b1;
                out_empty = 1'b1;
                out_pal   = 1'b1;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
            dcnt_reg    <= '0;
            idx_reg     <= '0;
            pal_reg     <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dcnt_reg    <= dcnt_next;
            idx_reg     <= idx_next;
            pal_reg     <= pal_next;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        if (item_take)
            base_reg <= item_ctrl.base;
    end

    // digit store, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= rem_step;
        if (rd_en_a)
            rd_a_reg <= mem[rd_addr_a];
        if (rd_en_b)
            rd_b_reg <= mem[rd_addr_b];
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digit_char_reg   <= out_char;
            last_digit_reg   <= out_last;
            empty_string_reg <= out_empty;
            palindrome_reg   <= out_pal;
        end
    end

    assign empty        = !out_valid_reg;
    assign digit_char   = digit_char_reg;
    assign last_digit   = last_digit_reg;
    assign empty_string = empty_string_reg;
    assign palindrome   = palindrome_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> pop)
        else $error("result word overwritten before it was taken");
    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < base_reg)
        else $error("partial remainder not below radix");
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_string_reg) |-> (last_digit_reg && palindrome_reg))
        else $error("empty-string word not marked last and palindrome");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/radix_digit_string_palindrome_unit.sv =====
// top level: integer to radix digit string with palindrome flag
// sequence: a zero number gives a single empty-string word; any other number has all its digits
//   divided out and checked for a palindrome, then one word per digit, most significant first
// flow: the back end takes a new number only once it is done with the last, and each word waits
//   for a free result slot; the queue fills meanwhile
// reset: asynchronous, active low; clears queue, sequencer and result, radix to ten
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_string_palindrome_unit #(
    parameter int VALUE_BITS = rdsp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdsp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          radix_we,
    input  wire logic [rdsp_pkg::RADIX_W-1:0]  radix_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [VALUE_BITS-1:0]         number,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [rdsp_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit,
    output logic                               empty_string,
    output logic                               palindrome
);
    import rdsp_pkg::*;

    logic                  item_valid;
    logic                  item_take;
    logic [VALUE_BITS-1:0] item_value;
    rdsp_ctrl_t            item_ctrl;

    // accept and classify
    rdsp_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .push        (push),
        .full        (full),
        .number      (number),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item_value  (item_value),
        .item_ctrl   (item_ctrl)
    );

    // convert and emit
    rdsp_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_value   (item_value),
        .item_ctrl    (item_ctrl),
        .empty        (empty),
        .pop          (pop),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .empty_string (empty_string),
        .palindrome   (palindrome)
    );

endmodule

`default_nettype wire
